// File: hw/rtl/ashg_pkg.sv
// Shared types and constants for the air sensor history graph block.
package ashg_pkg;
    localparam int Depth = 64;
    localparam int RecentCount = 10;
    localparam int PosW = $clog2(Depth);
    localparam int RecW = $clog2(RecentCount + 1);
    localparam int ValW = 14;

    localparam logic [2:0] FUNC_READ = 3'd0;
    localparam logic [2:0] FUNC_COMMIT = 3'd1;
    localparam logic [2:0] FUNC_RENDER = 3'd2;
    localparam logic [2:0] FUNC_LIVE = 3'd3;
    localparam logic [2:0] FUNC_RECENT = 3'd4;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_CO2_GOOD = 3'd1;
    localparam logic [2:0] REG_TVOC_GOOD = 3'd2;
    localparam logic [2:0] REG_CO2_FAIR = 3'd3;
    localparam logic [2:0] REG_TVOC_FAIR = 3'd4;

    localparam logic [1:0] Q_GOOD = 2'd0;
    localparam logic [1:0] Q_FAIR = 2'd1;
    localparam logic [1:0] Q_POOR = 2'd2;

    typedef struct packed {
        logic [ValW-1:0] co2_good;
        logic [ValW-1:0] tvoc_good;
        logic [ValW-1:0] co2_fair;
        logic [ValW-1:0] tvoc_fair;
    } limits_t;
endpackage

// File: hw/rtl/ashg_div.sv
// Restoring divider for the bar scale: 22-bit dividend by 14-bit divisor, one bit a cycle.
module ashg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [21:0] dividend,
    input  logic [13:0] divisor,
    output logic        done,
    output logic [21:0] quotient
);
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [14:0] rem_reg;
    logic [21:0] q_reg;
    logic [13:0] dv_reg;
    logic [14:0] shifted;
    logic [15:0] diff;

    assign shifted = {rem_reg[13:0], q_reg[21]};
    assign diff = {1'b0, shifted} - {2'b00, dv_reg};
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'd0;
                rem_reg <= '0;
                q_reg <= dividend;
                dv_reg <= divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[15])
                begin
                    rem_reg <= diff[14:0];
                    q_reg <= {q_reg[20:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    q_reg <= {q_reg[20:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd21)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: hw/rtl/air_sensor_history_graph.sv
// Top level of the air sensor history graph block.
// Words enter on the input channel (valid/stall) and results leave on the
// output channel (valid/stall). A reading (func 0) or commit (func 1)
// gives no result. A live quality query gives one word; a recent quality
// query walks back over up to the last ten entries, one memory read per
// entry, stops at the first good one and gives one word. A render gives
// 64 words, oldest first, the last marked by last: one pass of 64 reads
// finds the bounds, then every entry is read, divided in the bit-serial
// divider where the quotient is worth computing, and put out as one word.
// Input stall is high from acceptance until the final word of the item is
// taken. When the receiver stalls, the held word stays and the sequencer
// waits. Reset sets the height and limit registers to their defaults,
// clears the smoothed values and write position, and then sweeps both
// history memories to zero, during which input stall stays high;
// configuration writes are taken throughout. Unknown functions are
// accepted and dropped.
module air_sensor_history_graph (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] co2_raw,
    input  logic [15:0] tvoc_raw,
    input  logic        channel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  bar_value,
    output logic [1:0]  quality,
    output logic [13:0] scale_low,
    output logic [13:0] scale_high,
    output logic        last
);
    localparam int W = ashg_pkg::ValW;
    localparam int PW = ashg_pkg::PosW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_SCALE, S_BAR_RD, S_BAR_DATA,
        S_BAR_DIV, S_OUT, S_REC_RD, S_REC, S_LIVE
    } state_t;

    state_t state_reg;
    logic [7:0] height_reg;
    ashg_pkg::limits_t lim_reg;
    logic [W-1:0] co2_s_reg, tvoc_s_reg;
    logic [PW-1:0] wpos_reg;
    logic [W-1:0] co2_mem [ashg_pkg::Depth];
    logic [W-1:0] tvoc_mem [ashg_pkg::Depth];
    logic [W-1:0] rd_c_reg, rd_t_reg;
    logic [PW:0] idx_reg;
    logic [PW-1:0] rd_addr;
    logic mem_we;
    logic [PW-1:0] mem_wa;
    logic [W-1:0] mem_wc, mem_wt;
    logic chan_reg;
    logic [W-1:0] lo_reg, hi_reg;
    logic [14:0] div_reg;
    logic [ashg_pkg::RecW-1:0] fair_reg, poor_reg;
    logic [PW-1:0] rpos_reg;
    logic done_last_reg;
    logic [W-1:0] a_cur;
    logic [15:0] c_cl, t_cl;
    logic [1:0] cls_live, cls_hist;
    logic div_start;
    logic [21:0] div_num;
    logic div_done;
    logic [21:0] div_q;
    logic [W-1:0] diff_a;
    logic [W-1:0] div_mag;
    logic [26:0] hi_prod;
    logic [6:0] hi_quo;
    logic [W-1:0] hi_rnd;
    logic [W-1:0] lo_new;
    logic [14:0] span;

    function automatic logic [1:0] classify(input logic [W-1:0] c, input logic [W-1:0] t,
                                            input ashg_pkg::limits_t l);
        if (c < l.co2_good && t < l.tvoc_good)
            return ashg_pkg::Q_GOOD;
        if (c < l.co2_fair && t < l.tvoc_fair)
            return ashg_pkg::Q_FAIR;
        return ashg_pkg::Q_POOR;
    endfunction

    assign a_cur = chan_reg ? rd_t_reg : rd_c_reg;
    assign cls_live = classify(co2_s_reg, tvoc_s_reg, lim_reg);
    assign cls_hist = classify(rd_c_reg, rd_t_reg, lim_reg);
    assign c_cl = (co2_raw < 16'd400) ? 16'd400 : (co2_raw > 16'd9999) ? 16'd9999 : co2_raw;
    assign t_cl = (tvoc_raw == 16'd0) ? 16'd1 : (tvoc_raw > 16'd9999) ? 16'd9999 : tvoc_raw;
    // The maximum is below 10000, where multiplying by 5243 and dropping 19 bits divides by 100.
    assign hi_prod = 27'(hi_reg) * 27'd5243;
    assign hi_quo = hi_prod[25:19];
    assign hi_rnd = W'((14'(hi_quo) + 14'd1) * 14'd100);
    assign lo_new = chan_reg ? ((lo_reg < 14'd200) ? 14'd0 : 14'd100)
                             : ((lo_reg < 14'd600) ? 14'd400 : lo_reg);
    assign span = {1'b0, hi_rnd} - {1'b0, lo_new};
    assign diff_a = (a_cur > lo_reg) ? a_cur - lo_reg : lo_reg - a_cur;
    assign div_mag = div_reg[14] ? W'(15'd0 - div_reg) : div_reg[13:0];
    assign div_num = 22'(diff_a) * 22'(height_reg);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        rd_addr = idx_reg[PW-1:0];
        if (state_reg == S_BAR_RD)
            rd_addr = PW'(wpos_reg + idx_reg[PW-1:0]);
        else if (state_reg == S_REC_RD)
            rd_addr = rpos_reg;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = wpos_reg;
        mem_wc = co2_s_reg;
        mem_wt = tvoc_s_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = idx_reg[PW-1:0];
            mem_wc = '0;
            mem_wt = '0;
        end
        else if (state_reg == S_IDLE && in_valid && func == ashg_pkg::FUNC_COMMIT)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            co2_mem[mem_wa] <= mem_wc;
            tvoc_mem[mem_wa] <= mem_wt;
        end
        rd_c_reg <= co2_mem[rd_addr];
        rd_t_reg <= tvoc_mem[rd_addr];
    end

    // The quotient is only worth computing when the offset and the span have the same sign.
    assign div_start = (state_reg == S_BAR_DATA) && (a_cur != '0) && (div_reg != '0)
                       && ((a_cur > lo_reg) != div_reg[14]) && (div_num != '0);

    ashg_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(div_mag), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            height_reg <= 8'd46;
            lim_reg <= '{co2_good: 14'd800, tvoc_good: 14'd220,
                         co2_fair: 14'd1400, tvoc_fair: 14'd600};
            co2_s_reg <= '0;
            tvoc_s_reg <= '0;
            wpos_reg <= '0;
            idx_reg <= '0;
            out_valid <= 1'b0;
            last <= 1'b0;
            done_last_reg <= 1'b0;
            chan_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ashg_pkg::REG_HEIGHT: height_reg <= cfg_data[7:0];
                    ashg_pkg::REG_CO2_GOOD: lim_reg.co2_good <= cfg_data;
                    ashg_pkg::REG_TVOC_GOOD: lim_reg.tvoc_good <= cfg_data;
                    ashg_pkg::REG_CO2_FAIR: lim_reg.co2_fair <= cfg_data;
                    ashg_pkg::REG_TVOC_FAIR: lim_reg.tvoc_fair <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (PW+1)'(ashg_pkg::Depth - 1))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg <= '0;
                        chan_reg <= channel;
                        fair_reg <= '0;
                        poor_reg <= '0;
                        rpos_reg <= wpos_reg - 1'b1;
                        case (func)
                            ashg_pkg::FUNC_READ:
                            begin
                                co2_s_reg <= W'({2'b0, co2_s_reg[W-1:1]} + c_cl[15:1]);
                                tvoc_s_reg <= W'({2'b0, tvoc_s_reg[W-1:1]} + t_cl[15:1]);
                            end
                            ashg_pkg::FUNC_COMMIT: wpos_reg <= wpos_reg + 1'b1;
                            ashg_pkg::FUNC_RENDER: state_reg <= S_SCAN_RD;
                            ashg_pkg::FUNC_LIVE: state_reg <= S_LIVE;
                            ashg_pkg::FUNC_RECENT: state_reg <= S_REC_RD;
                            default: ;
                        endcase
                    end
                end
                S_LIVE:
                begin
                    bar_value <= '0;
                    quality <= cls_live;
                    scale_low <= '0;
                    scale_high <= '0;
                    last <= 1'b1;
                    out_valid <= 1'b1;
                    done_last_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_REC_RD:
                    state_reg <= S_REC;
                S_REC:
                begin
                    if (cls_hist == ashg_pkg::Q_GOOD || idx_reg == (PW+1)'(ashg_pkg::RecentCount - 1))
                    begin
                        bar_value <= '0;
                        scale_low <= '0;
                        scale_high <= '0;
                        last <= 1'b1;
                        out_valid <= 1'b1;
                        done_last_reg <= 1'b1;
                        state_reg <= S_OUT;
                        if (cls_hist == ashg_pkg::Q_GOOD)
                            quality <= ashg_pkg::Q_GOOD;
                        else if (cls_hist == ashg_pkg::Q_FAIR)
                            quality <= (fair_reg + 1'b1 < poor_reg) ? ashg_pkg::Q_FAIR
                                                                    : ashg_pkg::Q_POOR;
                        else
                            quality <= (fair_reg < poor_reg + 1'b1) ? ashg_pkg::Q_FAIR
                                                                    : ashg_pkg::Q_POOR;
                    end
                    else
                    begin
                        if (cls_hist == ashg_pkg::Q_FAIR)
                            fair_reg <= fair_reg + 1'b1;
                        else
                            poor_reg <= poor_reg + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        rpos_reg <= rpos_reg - 1'b1;
                        state_reg <= S_REC_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == (PW+1)'(1))
                    begin
                        lo_reg <= a_cur;
                        hi_reg <= a_cur;
                    end
                    else if (a_cur != '0)
                    begin
                        if (a_cur > hi_reg)
                            hi_reg <= a_cur;
                        if (a_cur < lo_reg)
                            lo_reg <= a_cur;
                    end
                    if (idx_reg == (PW+1)'(ashg_pkg::Depth))
                        state_reg <= S_SCALE;
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCALE:
                begin
                    hi_reg <= hi_rnd;
                    lo_reg <= lo_new;
                    div_reg <= ($signed(span) < 15'sd10) ? span + 15'd20 : span;
                    idx_reg <= '0;
                    state_reg <= S_BAR_RD;
                end
                S_BAR_RD:
                    state_reg <= S_BAR_DATA;
                S_BAR_DATA:
                begin
                    scale_low <= lo_reg;
                    scale_high <= hi_reg;
                    quality <= ashg_pkg::Q_GOOD;
                    last <= (idx_reg == (PW+1)'(ashg_pkg::Depth - 1));
                    done_last_reg <= (idx_reg == (PW+1)'(ashg_pkg::Depth - 1));
                    if (div_start)
                        state_reg <= S_BAR_DIV;
                    else
                    begin
                        bar_value <= (a_cur == '0) ? 8'd0 : 8'd1;
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_BAR_DIV:
                begin
                    if (div_done)
                    begin
                        bar_value <= (div_q == '0) ? 8'd1
                                   : (div_q > 22'd255) ? 8'd255 : div_q[7:0];
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        last <= 1'b0;
                        if (done_last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_BAR_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/sv/ashg_checker.sv
// Checker that predicts the air sensor history graph results and compares them.
module ashg_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] co2_raw,
    input  logic [15:0] tvoc_raw,
    input  logic        channel,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  bar_value,
    input  logic [1:0]  quality,
    input  logic [13:0] scale_low,
    input  logic [13:0] scale_high,
    input  logic        last,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  bar;
        logic [1:0]  qual;
        logic [13:0] lo;
        logic [13:0] hi;
        logic        fin;
    } word_t;

    word_t       expected_words[$];
    logic [7:0]  height;
    logic [13:0] co2_good, tvoc_good, co2_fair, tvoc_fair;
    logic [13:0] co2_ring[ashg_pkg::Depth];
    logic [13:0] tvoc_ring[ashg_pkg::Depth];
    logic [13:0] co2_avg, tvoc_avg;
    logic [ashg_pkg::PosW-1:0] wpos;

    assign pending = expected_words.size();

    function automatic logic [1:0] grade(input logic [13:0] c, input logic [13:0] t);
        if (c < co2_good && t < tvoc_good)
            return ashg_pkg::Q_GOOD;
        if (c < co2_fair && t < tvoc_fair)
            return ashg_pkg::Q_FAIR;
        return ashg_pkg::Q_POOR;
    endfunction

    function automatic logic [7:0] bar_height(input int a, input int lo, input int dv);
        int num;
        int q;
        num = (a - lo) * int'(height);
        if (dv == 0 || num == 0)
            return 8'd1;
        if ((num > 0) != (dv > 0))
            return 8'd1;
        q = (num > 0 ? num : -num) / (dv > 0 ? dv : -dv);
        if (q == 0)
            return 8'd1;
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    task automatic predict_render(input logic ch);
        int lo, hi, d, dv, a, k;
        word_t w;
        lo = ch ? int'(tvoc_ring[0]) : int'(co2_ring[0]);
        hi = lo;
        for (int i = 0; i < ashg_pkg::Depth; i++)
        begin
            a = ch ? int'(tvoc_ring[i]) : int'(co2_ring[i]);
            if (a > 0)
            begin
                if (a > hi)
                    hi = a;
                if (a < lo)
                    lo = a;
            end
        end
        hi = (hi / 100 + 1) * 100;
        if (!ch)
            lo = (lo < 600) ? 400 : lo;
        else
            lo = (lo < 200) ? 0 : 100;
        d = hi - lo;
        dv = (d < 10) ? d + 20 : d;
        for (int i = 0; i < ashg_pkg::Depth; i++)
        begin
            k = (int'(wpos) + i) % ashg_pkg::Depth;
            a = ch ? int'(tvoc_ring[k]) : int'(co2_ring[k]);
            w.bar = (a == 0) ? 8'd0 : bar_height(a, lo, dv);
            w.qual = ashg_pkg::Q_GOOD;
            w.lo = lo[13:0];
            w.hi = hi[13:0];
            w.fin = (i == ashg_pkg::Depth - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_recent();
        int fair, poor;
        logic [ashg_pkg::PosW-1:0] p;
        logic [1:0] c;
        logic found;
        word_t w;
        fair = 0;
        poor = 0;
        found = 0;
        p = wpos;
        for (int i = 0; i < ashg_pkg::RecentCount; i++)
        begin
            p = p - 1'b1;
            c = grade(co2_ring[p], tvoc_ring[p]);
            if (c == ashg_pkg::Q_GOOD)
            begin
                found = 1;
                break;
            end
            if (c == ashg_pkg::Q_FAIR)
                fair++;
            else
                poor++;
        end
        w = '0;
        w.qual = found ? ashg_pkg::Q_GOOD
                       : ((fair < poor) ? ashg_pkg::Q_FAIR : ashg_pkg::Q_POOR);
        w.fin = 1;
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [13:0] c, t;
        word_t w, got;
        if (!rst_n)
        begin
            height <= 8'd46;
            co2_good <= 14'd800;
            tvoc_good <= 14'd220;
            co2_fair <= 14'd1400;
            tvoc_fair <= 14'd600;
            for (int i = 0; i < ashg_pkg::Depth; i++)
            begin
                co2_ring[i] = '0;
                tvoc_ring[i] = '0;
            end
            co2_avg = '0;
            tvoc_avg = '0;
            wpos = '0;
            errors = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ashg_pkg::REG_HEIGHT:    height <= cfg_data[7:0];
                    ashg_pkg::REG_CO2_GOOD:  co2_good <= cfg_data;
                    ashg_pkg::REG_TVOC_GOOD: tvoc_good <= cfg_data;
                    ashg_pkg::REG_CO2_FAIR:  co2_fair <= cfg_data;
                    ashg_pkg::REG_TVOC_FAIR: tvoc_fair <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = {bar_value, quality, scale_low, scale_high, last};
                if (expected_words.size() == 0)
                begin
                    $display("%t unexpected word %h", $realtime, got);
                    errors++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (w.bar != bar_value)
                        $display("%t bar_value exp %0d got %0d", $realtime, w.bar, bar_value);
                    if (w.qual != quality)
                        $display("%t quality exp %0d got %0d", $realtime, w.qual, quality);
                    if (w.lo != scale_low)
                        $display("%t scale_low exp %0d got %0d", $realtime, w.lo, scale_low);
                    if (w.hi != scale_high)
                        $display("%t scale_high exp %0d got %0d", $realtime, w.hi, scale_high);
                    if (w.fin != last)
                        $display("%t last exp %0d got %0d", $realtime, w.fin, last);
                    if (w != got)
                        errors++;
                end
            end
            if (in_valid && !in_stall)
            begin
                case (func)
                    ashg_pkg::FUNC_READ:
                    begin
                        c = (co2_raw < 400) ? 14'd400
                          : (co2_raw > 9999) ? 14'd9999 : co2_raw[13:0];
                        t = (tvoc_raw == 0) ? 14'd1
                          : (tvoc_raw > 9999) ? 14'd9999 : tvoc_raw[13:0];
                        co2_avg = (co2_avg >> 1) + (c >> 1);
                        tvoc_avg = (tvoc_avg >> 1) + (t >> 1);
                    end
                    ashg_pkg::FUNC_COMMIT:
                    begin
                        co2_ring[wpos] = co2_avg;
                        tvoc_ring[wpos] = tvoc_avg;
                        wpos = wpos + 1'b1;
                    end
                    ashg_pkg::FUNC_RENDER: predict_render(channel);
                    ashg_pkg::FUNC_LIVE:
                    begin
                        w = '0;
                        w.qual = grade(co2_avg, tvoc_avg);
                        w.fin = 1;
                        expected_words.push_back(w);
                    end
                    ashg_pkg::FUNC_RECENT: predict_recent();
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// Top of the air sensor history graph testbench: stimulus, configuration and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [15:0] co2_raw = '0;
    logic [15:0] tvoc_raw = '0;
    logic        channel = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [7:0]  bar_value;
    logic [1:0]  quality;
    logic [13:0] scale_low, scale_high;
    logic        last;
    int          errors, pending;
    int          hold_cycles = 0;
    int          out_wait = 0;
    logic        hold_go = 0;
    logic        hold_used = 0;

    always #4 clk = ~clk;

    air_sensor_history_graph dut (.*);
    ashg_checker checker_i (.*);

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic send(input logic [2:0] f, input logic [15:0] c, input logic [15:0] t,
                        input logic ch);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        co2_raw <= c;
        tvoc_raw <= t;
        channel <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send(ashg_pkg::FUNC_READ,
                 (r < 5) ? 16'($urandom) : 16'($urandom_range(300, 3000)),
                 (r < 8) ? 16'($urandom) : 16'($urandom_range(0, 1200)), 1'b0);
        else if (r < 70)
            send(ashg_pkg::FUNC_COMMIT, 16'($urandom), 16'($urandom), 1'($urandom));
        else if (r < 78)
            send(ashg_pkg::FUNC_RENDER, 16'($urandom), 16'($urandom), 1'($urandom));
        else if (r < 86)
            send(ashg_pkg::FUNC_LIVE, 16'($urandom), 16'($urandom), 1'($urandom));
        else if (r < 96)
            send(ashg_pkg::FUNC_RECENT, 16'($urandom), 16'($urandom), 1'($urandom));
        else
            send(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    always @(posedge clk)
    begin
        int draw;
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_go && !hold_used)
        begin
            out_stall <= 1'b1;
            hold_cycles <= 400;
            hold_used <= 1'b1;
        end
        else if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait <= out_wait - 1;
        end
        else if (out_valid && !out_stall)
        begin
            draw = $urandom_range(0, 3);
            out_stall <= (draw > 0);
            out_wait <= (draw > 0) ? draw - 1 : 0;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #20ms;
        $display("air_sensor_history_graph: mismatch");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(ashg_pkg::FUNC_RENDER, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_RENDER, '0, '0, 1'b1);
        send(ashg_pkg::FUNC_RECENT, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_LIVE, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_READ, 16'd399, 16'd1, 1'b0);
        send(ashg_pkg::FUNC_COMMIT, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_RENDER, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_READ, 16'hFFFF, 16'hFFFF, 1'b0);
        send(ashg_pkg::FUNC_COMMIT, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_READ, '0, '0, 1'b1);
        send(ashg_pkg::FUNC_COMMIT, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_READ, 16'd399, 16'd1, 1'b0);
        send(ashg_pkg::FUNC_READ, 16'd10000, 16'd10000, 1'b0);
        send(ashg_pkg::FUNC_COMMIT, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_LIVE, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_RECENT, '0, '0, 1'b0);
        send(3'd5, 16'hAAAA, 16'h5555, 1'b1);
        send(3'd7, 16'h5555, 16'hAAAA, 1'b0);
        send(ashg_pkg::FUNC_RENDER, '0, '0, 1'b0);
        send(ashg_pkg::FUNC_RENDER, '0, '0, 1'b1);
        drain();
        write_reg(ashg_pkg::REG_HEIGHT, 14'd255);
        write_reg(ashg_pkg::REG_CO2_GOOD, 14'd16383);
        write_reg(ashg_pkg::REG_TVOC_GOOD, 14'd0);
        write_reg(ashg_pkg::REG_CO2_FAIR, 14'd0);
        write_reg(ashg_pkg::REG_TVOC_FAIR, 14'd16383);
        cfg_we <= 1'b0;
        for (int i = 0; i < 60; i++)
        begin
            if (i == 30)
                hold_go <= 1'b1;
            random_item();
        end
        drain();
        write_reg(ashg_pkg::REG_HEIGHT, 14'd1);
        write_reg(ashg_pkg::REG_CO2_GOOD, 14'd1200);
        write_reg(ashg_pkg::REG_TVOC_GOOD, 14'd300);
        write_reg(ashg_pkg::REG_CO2_FAIR, 14'd2500);
        write_reg(ashg_pkg::REG_TVOC_FAIR, 14'd900);
        cfg_we <= 1'b0;
        for (int i = 0; i < 40; i++)
            random_item();
        drain();
        write_reg(ashg_pkg::REG_HEIGHT, 14'd46);
        write_reg(ashg_pkg::REG_CO2_GOOD, 14'd800);
        write_reg(ashg_pkg::REG_TVOC_GOOD, 14'd220);
        write_reg(ashg_pkg::REG_CO2_FAIR, 14'd1400);
        write_reg(ashg_pkg::REG_TVOC_FAIR, 14'd600);
        cfg_we <= 1'b0;
        for (int i = 0; i < 40; i++)
            random_item();
        drain();
        if (errors == 0)
            $display("air_sensor_history_graph: match");
        else
            $display("air_sensor_history_graph: mismatch");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/ashg_pkg.sv
hw/rtl/ashg_div.sv
hw/rtl/air_sensor_history_graph.sv
tb/sv/ashg_checker.sv
tb/sv/testbench.sv
